/* hdl/lge_pkg.sv */
// Shared types, codes and the B3/S23 cell rule for the life generation engine.
package lge_pkg;

    localparam int CFG_W   = 7;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int OP_W    = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;

    localparam logic [3:0] SURVIVE_COUNT = 4'd2;
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_WRITE,
        ST_READ
    } t_state;

    // A live cell survives with two or three live neighbors; a dead one is born with three.
    function automatic logic life_rule(input logic alive, input logic [3:0] count);
        life_rule = alive ? ((count == SURVIVE_COUNT) || (count == BIRTH_COUNT))
                          : (count == BIRTH_COUNT);
    endfunction

endpackage

/* hdl/life_generation_engine.sv */
// Top level of the life generation engine: row-wide board memory and its sequencer.
//
// The block keeps a Game of Life board (rule B3/S23) of up to MAX_ROWS by MAX_COLS cells.
// The board lives in one synchronous memory with one row of MAX_COLS cells per entry.
// Input transactions (i_in_valid / o_in_stall) carry an operation: write a cell, advance
// one generation, or read a cell. Only a read produces an output transaction
// (o_out_valid / i_out_stall) carrying o_cell_alive. Board width and height are set
// through the APB port, register 0 at address 0 and register 1 at address 4.
// A cell write reads the row, patches it and writes it back.
// A read goes through the registered memory read port and then the output register; its
// result waits there while the receiver stalls. A new transaction can be accepted while
// that result waits; a second read then holds in its read state until the output
// register frees up.
// A generation step walks the memory rows in order: the memory read port streams the
// row below while the rows above and at the cursor sit in registers, so each new row
// is written back in place.
// After reset the memory is swept to all dead, one row per cycle; o_in_stall stays high
// during that sweep while APB writes are still taken.
module life_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lge_pkg::OP_W-1:0]      i_operation,
    input  logic [lge_pkg::ROW_W-1:0]     i_row,
    input  logic [lge_pkg::COL_W-1:0]     i_column,
    input  logic                          i_cell_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_cell_alive,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lge_pkg::PADDR_W-1:0]   paddr,
    input  logic [lge_pkg::PDATA_W-1:0]   pwdata,
    output logic [lge_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RCW = (($clog2(MAX_ROWS + 1) > lge_pkg::CFG_W) ?
                          $clog2(MAX_ROWS + 1) : lge_pkg::CFG_W) + 1;
    localparam int CCW = (($clog2(MAX_COLS + 1) > lge_pkg::CFG_W) ?
                          $clog2(MAX_COLS + 1) : lge_pkg::CFG_W) + 1;

    // Board memory, one row per entry.
    logic [MAX_COLS-1:0] r_cell_grid [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rdata;
    logic [RAW-1:0]      rd_addr;
    logic [RAW-1:0]      wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                wr_en;

    // Configuration registers.
    logic [lge_pkg::CFG_W-1:0] r_board_width;
    logic [lge_pkg::CFG_W-1:0] r_board_height;

    // Sequencer state.
    lge_pkg::t_state r_state, n_state;
    logic [RCW-1:0]  r_row, n_row;

    // Row window for a generation step: the row above and the row at the cursor.
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_cur, n_cur;

    // Operands of the cell operation in flight.
    logic [lge_pkg::ROW_W-1:0] r_op_row, n_op_row;
    logic [lge_pkg::COL_W-1:0] r_op_col, n_op_col;
    logic                      r_op_val, n_op_val;
    logic                      r_inside, n_inside;

    // Output register.
    logic r_out_valid, n_out_valid;
    logic r_cell_alive, n_cell_alive;

    logic [RCW-1:0]      used_rows;
    logic [CCW-1:0]      used_cols;
    logic [MAX_COLS-1:0] col_mask;
    logic                in_accept;
    logic                in_inside;
    logic                below_ok;
    logic [MAX_COLS-1:0] life_row;
    logic [MAX_COLS-1:0] patched_row;

    // Register values above the memory size are treated as the memory size.
    assign used_rows = (RCW'(r_board_height) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                              : RCW'(r_board_height);
    assign used_cols = (CCW'(r_board_width) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS)
                                                             : CCW'(r_board_width);

    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_inside  = (RCW'(i_row) < used_rows) && (CCW'(i_column) < used_cols);
    assign o_in_stall = (r_state != lge_pkg::ST_IDLE);
    assign below_ok   = (RCW'(r_row + RCW'(1)) < used_rows);

    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_cell_alive;
    assign pready       = 1'b1;

    // ---------------------------------------------------------------------------------
    // APB register file. Only address bit 2 selects the register.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_width  <= lge_pkg::WIDTH_RESET;
            r_board_height <= lge_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                lge_pkg::REG_WIDTH:  r_board_width  <= pwdata[lge_pkg::CFG_W-1:0];
                lge_pkg::REG_HEIGHT: r_board_height <= pwdata[lge_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lge_pkg::REG_WIDTH:  prdata = lge_pkg::PDATA_W'(r_board_width);
            lge_pkg::REG_HEIGHT: prdata = lge_pkg::PDATA_W'(r_board_height);
            default:             prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Board memory: one write port and one registered read port.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cell_grid[wr_addr] <= wr_data;
        end
        r_rdata <= r_cell_grid[rd_addr];
    end

    // ---------------------------------------------------------------------------------
    // Cell logic. Columns beyond the board width count as dead neighbors and keep their
    // stored values. The row below is dead past the board height.
    // ---------------------------------------------------------------------------------
    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            col_mask[j] = (CCW'(j) < used_cols);
        end
    end

    always_comb begin
        logic [MAX_COLS+1:0] pad_up;
        logic [MAX_COLS+1:0] pad_mid;
        logic [MAX_COLS+1:0] pad_dn;
        logic [MAX_COLS-1:0] below_row;
        logic [3:0]          cnt;
        below_row = below_ok ? r_rdata : '0;
        pad_up    = {1'b0, r_prev & col_mask, 1'b0};
        pad_mid   = {1'b0, r_cur & col_mask, 1'b0};
        pad_dn    = {1'b0, below_row & col_mask, 1'b0};
        for (int j = 0; j < MAX_COLS; j++) begin
            cnt = 4'(pad_up[j]) + 4'(pad_up[j+1]) + 4'(pad_up[j+2])
                + 4'(pad_mid[j]) + 4'(pad_mid[j+2])
                + 4'(pad_dn[j]) + 4'(pad_dn[j+1]) + 4'(pad_dn[j+2]);
            life_row[j] = col_mask[j] ? lge_pkg::life_rule(r_cur[j], cnt) : r_cur[j];
        end
    end

    // The row read for a cell write, with the addressed cell replaced.
    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            patched_row[j] = (CAW'(j) == CAW'(r_op_col)) ? r_op_val : r_rdata[j];
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lge_pkg::ST_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev       <= n_prev;
        r_cur        <= n_cur;
        r_op_row     <= n_op_row;
        r_op_col     <= n_op_col;
        r_op_val     <= n_op_val;
        r_inside     <= n_inside;
        r_cell_alive <= n_cell_alive;
    end

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_op_row     = r_op_row;
        n_op_col     = r_op_col;
        n_op_val     = r_op_val;
        n_inside     = r_inside;
        n_out_valid  = r_out_valid && i_out_stall;
        n_cell_alive = r_cell_alive;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = RAW'(r_row);
        wr_data      = '0;

        case (r_state)
            lge_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = RAW'(r_row);
                if (r_row == RCW'(MAX_ROWS - 1)) begin
                    n_row   = '0;
                    n_state = lge_pkg::ST_IDLE;
                end else begin
                    n_row = RCW'(r_row + RCW'(1));
                end
            end
            lge_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_op_row = i_row;
                    n_op_col = i_column;
                    n_op_val = i_cell_value;
                    n_inside = in_inside;
                    case (i_operation)
                        lge_pkg::OP_WRITE: begin
                            rd_addr = RAW'(i_row);
                            n_state = lge_pkg::ST_WRITE;
                        end
                        lge_pkg::OP_STEP: begin
                            rd_addr = '0;
                            n_state = (used_rows == '0) ? lge_pkg::ST_IDLE
                                                        : lge_pkg::ST_LOAD;
                        end
                        lge_pkg::OP_READ: begin
                            rd_addr = RAW'(i_row);
                            n_state = lge_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            lge_pkg::ST_LOAD: begin
                // Row 0 is arriving; fetch row 1 and start with a dead row above.
                n_prev  = '0;
                n_cur   = r_rdata;
                n_row   = '0;
                rd_addr = RAW'(1);
                n_state = lge_pkg::ST_STEP;
            end
            lge_pkg::ST_STEP: begin
                // The row below the cursor is arriving; write the new cursor row in place.
                wr_en   = 1'b1;
                wr_addr = RAW'(r_row);
                wr_data = life_row;
                n_prev  = r_cur;
                n_cur   = r_rdata;
                n_row   = RCW'(r_row + RCW'(1));
                rd_addr = RAW'(r_row + RCW'(2));
                if (!below_ok) begin
                    n_state = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_WRITE: begin
                wr_en   = r_inside;
                wr_addr = RAW'(r_op_row);
                wr_data = patched_row;
                n_state = lge_pkg::ST_IDLE;
            end
            lge_pkg::ST_READ: begin
                // Keep reading the same row so the data stays put while the output waits.
                rd_addr = RAW'(r_op_row);
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_cell_alive = r_inside && r_rdata[CAW'(r_op_col)];
                    n_state      = lge_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lge_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------------
    a_write_only_when_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == lge_pkg::ST_CLEAR || r_state == lge_pkg::ST_STEP ||
                   r_state == lge_pkg::ST_WRITE))
        else $error("board memory written outside clear, step or cell write");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == lge_pkg::ST_READ)
        else $error("result produced without a cell read");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation == lge_pkg::OP_STEP) |=>
            (r_state == lge_pkg::ST_LOAD || r_state == lge_pkg::ST_IDLE))
        else $error("generation step did not start with a row load");

endmodule

/* tb/sv/life_generation_engine_tb.sv */
// Self-checking testbench for the life generation engine: directed script plus random phases.
module life_generation_engine_tb;

    // Board limits of the instance under test.
    localparam int MAX_R = 64;
    localparam int MAX_C = 64;

    // Operation code 3 is left unused by the block; it must be swallowed without a result.
    localparam logic [lge_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // This margin covers a generation step that is still running, before any register
    // write and at the end of the run.
    localparam int SETTLE_CYCLES = MAX_R + 16;
    localparam int CYCLE_LIMIT   = 400000;

    localparam int SCRIPT_LEN  = 27;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 23;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [lge_pkg::OP_W-1:0]      i_operation;
    logic [lge_pkg::ROW_W-1:0]     i_row;
    logic [lge_pkg::COL_W-1:0]     i_column;
    logic                          i_cell_value;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_cell_alive;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lge_pkg::PADDR_W-1:0]   paddr;
    logic [lge_pkg::PDATA_W-1:0]   pwdata;
    logic [lge_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    life_generation_engine #(
        .MAX_ROWS(MAX_R),
        .MAX_COLS(MAX_C)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_operation(i_operation),
        .i_row(i_row),
        .i_column(i_column),
        .i_cell_value(i_cell_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cell_alive(o_cell_alive),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // One row of the directed script. The board size is part of each row: when it differs
    // from the current setting, the block is drained and both registers are rewritten.
    // Rows with has_fixed set carry an expected read value that is obvious by inspection;
    // all other reads are checked against the board model below.
    typedef struct {
        int unsigned               cfg_w;
        int unsigned               cfg_h;
        logic [lge_pkg::OP_W-1:0]  op;
        logic [lge_pkg::ROW_W-1:0] row;
        logic [lge_pkg::COL_W-1:0] col;
        logic                      value;
        bit                        has_fixed;
        bit                        fixed_alive;
    } t_script_row;

    t_script_row script [SCRIPT_LEN];

    // Board model: its own copy of the cells and of both size registers.
    bit                        board_cells [MAX_R][MAX_C];
    logic [lge_pkg::CFG_W-1:0] width_reg;
    logic [lge_pkg::CFG_W-1:0] height_reg;

    // Expected cell_alive values of reads that have been accepted but not yet answered.
    bit pending_alive [$];

    // When set, neither side inserts idle cycles, so back-to-back traffic is exercised.
    bit no_idle;
    int out_hold;

    int cycle_count;
    int error_count;
    int items_sent;
    int reads_checked;
    int steps_done;
    int settings_used;

    // Clock: period of 4 time units.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every mismatch goes through here: one line and one count.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s: got %0h, expected %0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // The register value takes effect clamped to the board limits.
    function automatic int used_cols();
        return (width_reg > MAX_C) ? MAX_C : int'(width_reg);
    endfunction

    function automatic int used_rows();
        return (height_reg > MAX_R) ? MAX_R : int'(height_reg);
    endfunction

    // One B3/S23 generation over the configured board only. Neighbors beyond the board
    // count as dead, and stored cells outside the board are left untouched.
    task automatic advance_board();
        bit fresh [MAX_R][MAX_C];
        int h;
        int w;
        int n;
        int rr;
        int cc;
        h = used_rows();
        w = used_cols();
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
                            n += board_cells[rr][cc];
                    end
                end
                // Survival needs two or three live neighbors, birth exactly three.
                fresh[r][c] = board_cells[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                board_cells[r][c] = fresh[r][c];
    endtask

    // Applies one accepted transaction to the board model and tells whether a read
    // result follows, and with which value.
    task automatic predict_txn(input logic [lge_pkg::OP_W-1:0] op,
                               input logic [lge_pkg::ROW_W-1:0] row,
                               input logic [lge_pkg::COL_W-1:0] col, input logic value,
                               output bit gives, output bit alive);
        bit on_board;
        on_board = (row < used_rows()) && (col < used_cols());
        gives = 1'b0;
        alive = 1'b0;
        case (op)
            lge_pkg::OP_WRITE: begin
                if (on_board)
                    board_cells[row][col] = value;
            end
            lge_pkg::OP_STEP: begin
                advance_board();
            end
            lge_pkg::OP_READ: begin
                gives = 1'b1;
                alive = on_board ? board_cells[row][col] : 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // Offers one input transaction after a random gap and holds it until it is taken.
    // Returns at the falling edge after acceptance with valid still high, so the next
    // call can follow without a bubble.
    task automatic send_txn(input logic [lge_pkg::OP_W-1:0] op,
                            input logic [lge_pkg::ROW_W-1:0] row,
                            input logic [lge_pkg::COL_W-1:0] col, input logic value,
                            input bit has_fixed, input bit fixed_alive);
        int gap;
        bit gives;
        bit alive;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation  = op;
        i_row        = row;
        i_column     = col;
        i_cell_value = value;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_txn(op, row, col, value, gives, alive);
        if (gives)
            pending_alive.push_back(has_fixed ? fixed_alive : alive);
        if (op == lge_pkg::OP_STEP)
            steps_done++;
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drains the block: no more input, every expected read answered, and then enough
    // quiet cycles for a step that was still running to finish its sweep.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_alive.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_read(input logic [0:0] idx,
                            output logic [lge_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes a size register, reads it back, and updates the model's copy.
    task automatic apb_write(input logic [0:0] idx, input logic [lge_pkg::CFG_W-1:0] value);
        logic [lge_pkg::PDATA_W-1:0] back;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = lge_pkg::PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == lge_pkg::REG_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        apb_read(idx, back);
        if (back !== lge_pkg::PDATA_W'(value))
            report_mismatch(idx == lge_pkg::REG_WIDTH ? "width readback" : "height readback",
                            back, lge_pkg::PDATA_W'(value));
    endtask

    task automatic set_board(input logic [lge_pkg::CFG_W-1:0] w,
                             input logic [lge_pkg::CFG_W-1:0] h);
        apb_write(lge_pkg::REG_WIDTH, w);
        apb_write(lge_pkg::REG_HEIGHT, h);
        settings_used++;
    endtask

    // Board dimension for a random phase: mostly small boards, where steps reach deep,
    // and now and then the empty board, the full board or an oversized setting.
    function automatic logic [lge_pkg::CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd64;
            2: return lge_pkg::CFG_W'($urandom_range(65, 127));
            default: return lge_pkg::CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Output side: stalls for a random number of cycles on every result, except while
    // the no-idle stretch is running.
    initial out_hold = 0;
    always @(negedge i_clk) begin
        if (o_out_valid && out_hold > 0) begin
            i_out_stall = 1'b1;
            out_hold--;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Result check: each accepted output transaction is matched with the oldest read.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_alive.size() == 0) begin
                report_mismatch("result with no read pending", 32'(o_cell_alive), 32'd0);
            end else begin
                if (o_cell_alive !== pending_alive[0])
                    report_mismatch("cell_alive", 32'(o_cell_alive), 32'(pending_alive[0]));
                void'(pending_alive.pop_front());
                reads_checked++;
            end
            out_hold = no_idle ? 0 : $urandom_range(0, 6);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reads still pending",
                     cycle_count, pending_alive.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [lge_pkg::PDATA_W-1:0] back;
        logic [lge_pkg::OP_W-1:0]    op;
        logic [lge_pkg::ROW_W-1:0]   row;
        logic [lge_pkg::COL_W-1:0]   col;
        logic [lge_pkg::CFG_W-1:0]   w;
        logic [lge_pkg::CFG_W-1:0]   h;
        int                          sel;

        // Every input is known from time zero, with reset held.
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = lge_pkg::OP_READ;
        i_row        = '0;
        i_column     = '0;
        i_cell_value = 1'b0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_idle      = 1'b0;
        cycle_count  = 0;
        error_count  = 0;
        items_sent   = 0;
        reads_checked = 0;
        steps_done   = 0;
        settings_used = 0;
        width_reg    = lge_pkg::WIDTH_RESET;
        height_reg   = lge_pkg::HEIGHT_RESET;
        for (int r = 0; r < MAX_R; r++)
            for (int c = 0; c < MAX_C; c++)
                board_cells[r][c] = 1'b0;

        // Directed script. A three-cell blinker is built at row 10 of the full board,
        // together with two lone corner cells that die on the first step. Later rows
        // cover the oversized setting, the empty board, writes and reads off the board,
        // a step that leaves the stored cells outside a shrunken board alone, and the
        // unused operation code.
        script = '{
            '{64,  64,  lge_pkg::OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd10, 6'd9,  1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd10, 6'd10, 1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd10, 6'd11, 1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd9,  6'd10, 1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd10, 6'd9,  1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_WRITE, 6'd9,  6'd10, 1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd9,  6'd10, 1'b0, 1'b0, 1'b0},
            '{64,  64,  OP_UNUSED,         6'd10, 6'd10, 1'b1, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd10, 6'd10, 1'b0, 1'b0, 1'b0},
            '{127, 127, lge_pkg::OP_WRITE, 6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
            '{127, 127, lge_pkg::OP_READ,  6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
            '{0,   0,   lge_pkg::OP_READ,  6'd10, 6'd10, 1'b0, 1'b1, 1'b0},
            '{0,   0,   lge_pkg::OP_WRITE, 6'd1,  6'd1,  1'b1, 1'b0, 1'b0},
            '{0,   0,   lge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
            '{8,   4,   lge_pkg::OP_WRITE, 6'd5,  6'd2,  1'b1, 1'b0, 1'b0},
            '{8,   4,   lge_pkg::OP_READ,  6'd2,  6'd8,  1'b0, 1'b1, 1'b0},
            '{8,   4,   lge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd10, 6'd10, 1'b0, 1'b0, 1'b0},
            '{64,  64,  lge_pkg::OP_READ,  6'd1,  6'd1,  1'b0, 1'b0, 1'b0}
        };

        // Synchronous reset, released on a falling edge.
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Both size registers must come out of reset at the full board.
        apb_read(lge_pkg::REG_WIDTH, back);
        if (back !== lge_pkg::PDATA_W'(lge_pkg::WIDTH_RESET))
            report_mismatch("width after reset", back,
                            lge_pkg::PDATA_W'(lge_pkg::WIDTH_RESET));
        apb_read(lge_pkg::REG_HEIGHT, back);
        if (back !== lge_pkg::PDATA_W'(lge_pkg::HEIGHT_RESET))
            report_mismatch("height after reset", back,
                            lge_pkg::PDATA_W'(lge_pkg::HEIGHT_RESET));

        // Walk the directed script. A change of board size always happens with the
        // block drained, which also pauses the sender until all reads are answered.
        for (int k = 0; k < SCRIPT_LEN; k++) begin
            if (lge_pkg::CFG_W'(script[k].cfg_w) != width_reg ||
                lge_pkg::CFG_W'(script[k].cfg_h) != height_reg) begin
                settle();
                set_board(lge_pkg::CFG_W'(script[k].cfg_w),
                          lge_pkg::CFG_W'(script[k].cfg_h));
            end
            send_txn(script[k].op, script[k].row, script[k].col, script[k].value,
                     script[k].has_fixed, script[k].fixed_alive);
        end

        // Random phases. Each one picks a board size, seeds the board with a burst of
        // mostly writes, and then mixes writes, reads and steps so that patterns evolve
        // over several generations. A small share of coordinates is drawn over the whole
        // field range so that writes and reads off the board keep happening.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0) begin
                w = 7'd64;
                h = 7'd64;
            end else if (p == PHASES - 1) begin
                w = 7'd1;
                h = 7'd1;
            end else begin
                w = pick_dim();
                h = pick_dim();
            end
            set_board(w, h);
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Halfway through the second phase the sender holds back until every
                // pending read has been answered.
                if (p == 1 && i == PHASE_ITEMS / 2) begin
                    i_in_valid = 1'b0;
                    while (pending_alive.size() != 0)
                        @(negedge i_clk);
                end
                sel = $urandom_range(0, 99);
                if (i < PHASE_ITEMS / 3)
                    op = (sel < 80) ? lge_pkg::OP_WRITE :
                         (sel < 95) ? lge_pkg::OP_READ : lge_pkg::OP_STEP;
                else
                    op = (sel < 40) ? lge_pkg::OP_WRITE :
                         (sel < 75) ? lge_pkg::OP_READ :
                         (sel < 93) ? lge_pkg::OP_STEP : OP_UNUSED;
                if (used_rows() > 0 && $urandom_range(0, 9) != 0)
                    row = lge_pkg::ROW_W'($urandom_range(0, used_rows() - 1));
                else
                    row = lge_pkg::ROW_W'($urandom_range(0, 63));
                if (used_cols() > 0 && $urandom_range(0, 9) != 0)
                    col = lge_pkg::COL_W'($urandom_range(0, used_cols() - 1));
                else
                    col = lge_pkg::COL_W'($urandom_range(0, 63));
                send_txn(op, row, col, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end
        end
        no_idle = 1'b0;

        // Let the last reads come back and any running step complete.
        settle();

        $display("Covered %0d input transactions and %0d reads over %0d board settings,",
                 items_sent, reads_checked, settings_used);
        $display("including %0d generation steps; %0d mismatches seen.",
                 steps_done, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/lge_pkg.sv
hdl/life_generation_engine.sv
tb/sv/life_generation_engine_tb.sv
